@@ design/lruc_pkg.sv @@
// Package for the LRU key-value cache: payload structs, sizes and codes.
// No dependencies; used by lruc_store and lru_key_value_cache.
package lruc_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int IDX_W = $clog2(NUM_ENTRIES);
   localparam int CNT_W = $clog2(NUM_ENTRIES + 1);
   localparam int CAP_W = 5;
   localparam int DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
   localparam logic [DATA_W-1:0] MISS_VALUE = '1;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } op_type;

   typedef enum logic {
      CSR_CAPACITY = 1'b0
   } csr_index_type;

   typedef struct packed {
      op_type opcode;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic hit;
      logic signed [DATA_W-1:0] read_value;
   } rsp_type;

endpackage

@@ design/lruc_store.sv @@
// Entry store of the LRU cache: keys, values, valid bits, recency ranks,
// parallel lookup, promote/evict/insert and the result register. Uses lruc_pkg.
module lruc_store
   import lruc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic [CAP_W-1:0] capacity,
   input  logic             op_valid,
   input  req_type          op,
   output logic             rsp_valid,
   output rsp_type          rsp
);

   logic [DATA_W-1:0] keys_ff [NUM_ENTRIES];
   logic [DATA_W-1:0] values_ff [NUM_ENTRIES];
   logic [NUM_ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0] rank_ff [NUM_ENTRIES];
   logic [IDX_W-1:0] rank_in [NUM_ENTRIES];
   logic [CNT_W-1:0] occ_ff, occ_in;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic [NUM_ENTRIES-1:0] hit_vec, victim_vec, free_vec;
   logic any_hit, full, evict;
   logic [IDX_W-1:0] found_idx, slot_idx, found_rank, widx;
   logic [CNT_W-1:0] cap_eff, last_rank;
   logic key_we, val_we;
   logic [DATA_W-1:0] wval;

   always_comb begin
      if (capacity == '0) begin
         cap_eff = CNT_W'(1);
      end else if ({{(CNT_W > CAP_W ? CNT_W - CAP_W : 0){1'b0}}, capacity} > CNT_W'(NUM_ENTRIES))
      begin
         cap_eff = CNT_W'(NUM_ENTRIES);
      end else begin
         cap_eff = CNT_W'(capacity);
      end
   end

   always_comb begin
      last_rank = occ_ff - CNT_W'(1);
      full = (occ_ff >= cap_eff);
      evict = full && (occ_ff != '0);
      found_idx = '0;
      slot_idx = '0;
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (keys_ff[i] == op.key);
         victim_vec[i] = valid_ff[i] && (CNT_W'(rank_ff[i]) == last_rank);
      end
      free_vec = ~valid_ff | (evict ? victim_vec : '0);
      for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            found_idx = IDX_W'(i);
         end
         if (free_vec[i]) begin
            slot_idx = IDX_W'(i);
         end
      end
      any_hit = |hit_vec;
      found_rank = rank_ff[found_idx];
   end

   always_comb begin
      valid_in = valid_ff;
      rank_in = rank_ff;
      occ_in = occ_ff;
      key_we = 1'b0;
      val_we = 1'b0;
      widx = found_idx;
      wval = op.write_value;
      if (op_valid) begin
         if (any_hit) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               if (valid_ff[i] && (rank_ff[i] < found_rank)) begin
                  rank_in[i] = rank_ff[i] + IDX_W'(1);
               end
            end
            rank_in[found_idx] = '0;
            val_we = (op.opcode == OP_PUT);
         end else if (op.opcode == OP_PUT) begin
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               if (valid_ff[i] && !(evict && victim_vec[i])) begin
                  rank_in[i] = rank_ff[i] + IDX_W'(1);
               end
            end
            if (evict) begin
               valid_in = valid_ff & ~victim_vec;
            end else begin
               occ_in = occ_ff + CNT_W'(1);
            end
            valid_in[slot_idx] = 1'b1;
            rank_in[slot_idx] = '0;
            widx = slot_idx;
            key_we = 1'b1;
            val_we = 1'b1;
         end
      end
   end

   always_comb begin
      rsp_in.hit = any_hit;
      if (op.opcode == OP_PUT) begin
         rsp_in.read_value = op.write_value;
      end else if (any_hit) begin
         rsp_in.read_value = values_ff[found_idx];
      end else begin
         rsp_in.read_value = MISS_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
         occ_ff <= '0;
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff <= occ_in;
         rank_ff <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         keys_ff[widx] <= op.key;
      end
      if (val_we) begin
         values_ff[widx] <= wval;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= op_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule

@@ design/lru_key_value_cache.sv @@
// Top level of the LRU key-value cache: command port, input register,
// capacity CSR on an APB-style port. Uses lruc_pkg and lruc_store.
// A transfer taken at an edge passes the input register, then the store's result register.
// Throughput: one transfer per cycle; busy stays low, results cannot be stalled.
// Reset: store empty, capacity 16, no result pending. A capacity write
// also empties the store in that same cycle.
module lru_key_value_cache
   import lruc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   logic [CAP_W-1:0] cap_ff;
   logic cap_write;
   logic req_valid_ff;
   req_type req_ff;

   assign busy = 1'b0;
   assign pready = 1'b1;
   assign cap_write = psel && penable && pwrite && pready
                      && (paddr[2] == CSR_CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (cap_write) begin
         cap_ff <= pwdata[CAP_W-1:0];
      end
   end

   always_comb begin
      if (paddr[2] == CSR_CAPACITY) begin
         prdata = {{(32 - CAP_W){1'b0}}, cap_ff};
      end else begin
         prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_payload;
      end
   end

   lruc_store u_store (
      .clock     (clock),
      .reset     (reset),
      .clear     (cap_write),
      .capacity  (cap_ff),
      .op_valid  (req_valid_ff),
      .op        (req_ff),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_payload)
   );

endmodule

@@ tb/lru_key_value_cache_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for lru_key_value_cache: fixed-result directed rows, then random
// get/put traffic under several capacities, checked by an LRU predictor. Uses lruc_pkg.
module lru_key_value_cache_test;
   import lruc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 140;

   typedef struct {
      logic                  is_csr;
      logic [CSR_ADDR_W-1:0] addr;
      logic [31:0]           data;
      req_type               req;
      logic                  typed;
      rsp_type               want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_payload;
   logic                  rsp_valid;
   rsp_type               rsp_payload;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   logic signed [DATA_W-1:0] ent_key [NUM_ENTRIES];
   logic signed [DATA_W-1:0] ent_value [NUM_ENTRIES];
   logic                     ent_valid [NUM_ENTRIES];
   logic [IDX_W-1:0]         ent_rank [NUM_ENTRIES];
   logic [CNT_W-1:0]         occupied;
   logic [CAP_W-1:0]         capacity;

   rsp_type pending_rsp [$];
   int      failures = 0;
   int      cycles = 0;
   logic    steady = 1'b0;

   lru_key_value_cache dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic plan_row_type op_row(op_type op, logic [31:0] k, logic [31:0] v,
                                           logic typed, logic h, logic [31:0] rv);
      plan_row_type p;
      p.is_csr = 1'b0;
      p.addr = '0;
      p.data = '0;
      p.req.opcode = op;
      p.req.key = k;
      p.req.write_value = v;
      p.typed = typed;
      p.want.hit = h;
      p.want.read_value = rv;
      return p;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_ADDR_W-1:0] a, logic [31:0] d);
      plan_row_type p;
      p = op_row(OP_GET, '0, '0, 1'b0, 1'b0, '0);
      p.is_csr = 1'b1;
      p.addr = a;
      p.data = d;
      return p;
   endfunction

   task automatic clear_cache();
      for (int i = 0; i < NUM_ENTRIES; i++) begin
         ent_valid[i] = 1'b0;
         ent_rank[i] = '0;
      end
      occupied = '0;
   endtask

   task automatic make_newest(input int idx);
      logic [IDX_W-1:0] r;
      r = ent_rank[idx];
      for (int i = 0; i < NUM_ENTRIES; i++)
         if (ent_valid[i] && ent_rank[i] < r) ent_rank[i] = ent_rank[i] + 1'b1;
      ent_rank[idx] = '0;
   endtask

   task automatic cache_access(input req_type r, output rsp_type o);
      int found;
      int slot;
      int eff_cap;
      logic done;
      found = -1;
      slot = -1;
      for (int i = 0; i < NUM_ENTRIES; i++)
         if (found < 0 && ent_valid[i] && ent_key[i] == r.key) found = i;
      if (r.opcode == OP_GET) begin
         if (found >= 0) begin
            make_newest(found);
            o.hit = 1'b1;
            o.read_value = ent_value[found];
         end else begin
            o.hit = 1'b0;
            o.read_value = MISS_VALUE;
         end
      end else if (found >= 0) begin
         ent_value[found] = r.write_value;
         make_newest(found);
         o.hit = 1'b1;
         o.read_value = r.write_value;
      end else begin
         eff_cap = (capacity == 0) ? 1 : (capacity > NUM_ENTRIES) ? NUM_ENTRIES : int'(capacity);
         if (int'(occupied) >= eff_cap && occupied > 0) begin
            done = 1'b0;
            for (int i = 0; i < NUM_ENTRIES; i++)
               if (!done && ent_valid[i] && int'(ent_rank[i]) == int'(occupied) - 1) begin
                  ent_valid[i] = 1'b0;
                  ent_rank[i] = '0;
                  occupied = occupied - 1'b1;
                  done = 1'b1;
               end
         end
         for (int i = 0; i < NUM_ENTRIES; i++)
            if (slot < 0 && !ent_valid[i]) slot = i;
         if (slot >= 0) begin
            for (int i = 0; i < NUM_ENTRIES; i++)
               if (ent_valid[i]) ent_rank[i] = ent_rank[i] + 1'b1;
            ent_key[slot] = r.key;
            ent_value[slot] = r.write_value;
            ent_valid[slot] = 1'b1;
            ent_rank[slot] = '0;
            occupied = occupied + 1'b1;
         end
         o.hit = 1'b0;
         o.read_value = r.write_value;
      end
   endtask

   task automatic issue(input req_type r, input logic typed, input rsp_type want);
      int gap;
      rsp_type o;
      gap = steady ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      cache_access(r, o);
      pending_rsp.push_back(typed ? want : o);
   endtask

   // write a CSR, then read back the capacity register; only with the cache drained
   task automatic csr_update(input logic [CSR_ADDR_W-1:0] a, input logic [31:0] d);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= a;
      pwdata <= d;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if ((a >> 2) == CSR_CAPACITY) begin
         capacity = d[CAP_W-1:0];
         clear_cache();
      end
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {CSR_CAPACITY, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== 32'(capacity)) begin
         $error("capacity: expected %0d, got %0d", capacity, prdata);
         failures++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected result transfer: hit %0b read_value %0h",
                   rsp_payload.hit, rsp_payload.read_value);
            failures++;
         end else begin
            if (rsp_payload.hit !== pending_rsp[0].hit) begin
               $error("hit: expected %0b, got %0b", pending_rsp[0].hit, rsp_payload.hit);
               failures++;
            end
            if (rsp_payload.read_value !== pending_rsp[0].read_value) begin
               $error("read_value: expected %0h, got %0h",
                      pending_rsp[0].read_value, rsp_payload.read_value);
               failures++;
            end
            void'(pending_rsp.pop_front());
         end
      end
   end

   initial begin
      plan_row_type plan [$];
      logic signed [DATA_W-1:0] key_pool [32];
      int pool_size;
      int eff_cap;
      logic [31:0] cap_word;
      req_type r;
      rsp_type none;

      reset <= 1'b1;
      start <= 1'b0;
      req_payload <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      none = '0;
      capacity = CAP_RESET;
      clear_cache();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      plan = '{
         op_row(OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE),
         op_row(OP_PUT, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 1'b0, 32'h8000_0000),
         op_row(OP_GET, 32'h7fff_ffff, 32'h1234_5678, 1'b1, 1'b1, 32'h8000_0000),
         op_row(OP_PUT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 1'b0, 32'h7fff_ffff),
         op_row(OP_PUT, 32'h8000_0000, 32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff),
         op_row(OP_GET, 32'h8000_0000, 32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff),
         op_row(OP_GET, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE),
         op_row(OP_PUT, 32'hffff_ffff, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000),
         op_row(OP_GET, 32'hffff_ffff, 32'h5555_aaaa, 1'b1, 1'b1, 32'h0000_0000),
         csr_row({CSR_CAPACITY, 2'b00}, 32'd2),
         op_row(OP_GET, 32'h7fff_ffff, 32'h0000_0000, 1'b1, 1'b0, MISS_VALUE),
         op_row(OP_PUT, 32'd10, 32'd100, 1'b1, 1'b0, 32'd100),
         op_row(OP_PUT, 32'd20, 32'd200, 1'b1, 1'b0, 32'd200),
         op_row(OP_GET, 32'd10, 32'd0, 1'b1, 1'b1, 32'd100),
         op_row(OP_PUT, 32'd30, 32'd300, 1'b1, 1'b0, 32'd300),
         op_row(OP_GET, 32'd20, 32'd0, 1'b1, 1'b0, MISS_VALUE),
         op_row(OP_GET, 32'd10, 32'd0, 1'b1, 1'b1, 32'd100),
         // register index 1 does not exist: no clear, capacity unchanged
         csr_row(3'd4, 32'd1),
         op_row(OP_GET, 32'd30, 32'd0, 1'b1, 1'b1, 32'd300),
         csr_row({CSR_CAPACITY, 2'b00}, 32'd0),
         op_row(OP_PUT, 32'd5, 32'd55, 1'b1, 1'b0, 32'd55),
         op_row(OP_PUT, 32'd6, 32'd66, 1'b1, 1'b0, 32'd66),
         op_row(OP_GET, 32'd5, 32'd0, 1'b1, 1'b0, MISS_VALUE),
         op_row(OP_GET, 32'd6, 32'd0, 1'b1, 1'b1, 32'd66),
         csr_row({CSR_CAPACITY, 2'b00}, 32'hffff_ffff)
      };
      foreach (plan[n]) begin
         if (plan[n].is_csr) csr_update(plan[n].addr, plan[n].data);
         else issue(plan[n].req, plan[n].typed, plan[n].want);
      end

      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: cap_word = 32'd16;
            1: cap_word = 32'd1;
            2: cap_word = 32'd0;
            3: cap_word = 32'd31;
            4: cap_word = 32'd2;
            5: cap_word = 32'd7;
            6: cap_word = $urandom_range(3, 15);
            7: cap_word = 32'({$urandom, 5'd0}) | 32'($urandom_range(17, 31));
            default: cap_word = 32'({$urandom, 5'd0}) | 32'd16;
         endcase
         csr_update({CSR_CAPACITY, 2'b00}, cap_word);
         eff_cap = (capacity == 0) ? 1 : (capacity > NUM_ENTRIES) ? NUM_ENTRIES : int'(capacity);
         pool_size = eff_cap + 1 + $urandom_range(0, 4);
         for (int i = 0; i < pool_size; i++) begin
            case ($urandom_range(0, 15))
               0: key_pool[i] = 32'h0000_0000;
               1: key_pool[i] = 32'h7fff_ffff;
               2: key_pool[i] = 32'h8000_0000;
               3: key_pool[i] = 32'hffff_ffff;
               default: key_pool[i] = $urandom;
            endcase
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 35 == 0) steady = ($urandom_range(0, 3) == 0);
            r.opcode = $urandom_range(0, 1) ? OP_PUT : OP_GET;
            r.key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, pool_size - 1)]
                                                  : $urandom;
            r.write_value = $urandom;
            issue(r, 1'b0, none);
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ lru_key_value_cache.f @@
design/lruc_pkg.sv
design/lruc_store.sv
design/lru_key_value_cache.sv
tb/lru_key_value_cache_test.sv
